// ===== src/cbal_pkg.sv =====
// Shared types, constants, coefficient ROM and microprogram for the cascaded
// biquad angle low-pass filter. No dependencies.
`default_nettype none

package cbal_pkg;

   localparam int SAMPLE_W     = 32;
   localparam int STATE_W      = 50;
   localparam int COEF_W       = 32;
   localparam int COEF_SHIFT   = 30;
   localparam int FRAC_BITS_DEF = 16;
   localparam int HISTORY_LEN  = 3;
   localparam int PAST         = HISTORY_LEN - 1;
   localparam int COEF_COUNT   = HISTORY_LEN + PAST;
   localparam int MAX_SECTIONS = 5;
   localparam int NUM_BANDS    = 4;
   localparam int BAND_W       = 2;
   localparam int SEC_W        = $clog2(MAX_SECTIONS);
   localparam int UPC_W        = 4;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_SELECT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYPASS      = 2'd1;

   // Band codes.
   localparam logic [BAND_W-1:0] BAND_100HZ = 2'd0;
   localparam logic [BAND_W-1:0] BAND_200HZ = 2'd1;
   localparam logic [BAND_W-1:0] BAND_300HZ = 2'd2;
   localparam logic [BAND_W-1:0] BAND_500HZ = 2'd3;

   // Microprogram addresses.
   localparam logic [UPC_W-1:0] UPC_IDLE      = 4'd0;
   localparam logic [UPC_W-1:0] UPC_MAC_FIRST = 4'd1;
   localparam logic [UPC_W-1:0] UPC_ACC_LAST  = 4'd11;
   localparam logic [UPC_W-1:0] UPC_SEC_END   = 4'd12;
   localparam logic [UPC_W-1:0] UPC_FINISH    = 4'd13;

   // Multiplier operand source; the coefficient slot has the same number.
   typedef enum logic [2:0] {
      SRC_TAP0,
      SRC_TAP1,
      SRC_TAP2,
      SRC_HIST0,
      SRC_HIST1
   } src_sel_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_GOTO,
      JMP_WAIT_REQ,
      JMP_MORE_SEC,
      JMP_WAIT_OUT
   } jump_type;

   typedef struct packed {
      src_sel_type       src;
      logic              half_hi;
      logic              acc_en;
      logic              sec_end;
      logic              finish;
      logic              load;
      jump_type          jump;
      logic [UPC_W-1:0]  target;
   } uword_type;

   // Control handed from the sequencer to the datapath each cycle.
   typedef struct packed {
      src_sel_type       src;
      logic              half_hi;
      logic              acc_en;
      logic              sec_end;
      logic              load_fire;
      logic              finish_fire;
      logic [SEC_W-1:0]  sec;
   } dp_ctrl_type;

   // Per band and section: b0, b1, b2, -a1, -a2 in signed Q2.30.
   // Feedback terms are stored negated so every step is a plain add.
   localparam logic signed [COEF_W-1:0] COEF_ROM [NUM_BANDS][MAX_SECTIONS][COEF_COUNT] = '{
      '{ '{32'sd1026796, 32'sd2053592, 32'sd1026796, 32'sd2051537075, -32'sd981902434},
         '{default: '0}, '{default: '0}, '{default: '0}, '{default: '0} },
      '{ '{32'sd9673353, 32'sd19346706, 32'sd9673353, 32'sd1915323213, -32'sd880274800},
         '{32'sd97612908, 32'sd97612908, 32'sd0, 32'sd878516008, 32'sd0},
         '{default: '0}, '{default: '0}, '{default: '0} },
      '{ '{32'sd29077621, 32'sd58155242, 32'sd29077621, 32'sd1780874534, -32'sd823443195},
         '{32'sd24962914, 32'sd49925829, 32'sd24962914, 32'sd1528867107, -32'sd554976940},
         '{default: '0}, '{default: '0}, '{default: '0} },
      '{ '{32'sd168039564, 32'sd336079127, 32'sd168039564, 32'sd1223861824,
           -32'sd822278255},
         '{32'sd137729435, 32'sd275458869, 32'sd137729435, 32'sd1003107800,
           -32'sd480283714},
         '{32'sd120073470, 32'sd240146940, 32'sd120073470, 32'sd874516290,
           -32'sd281068345},
         '{32'sd110802399, 32'sd221604799, 32'sd110802399, 32'sd806993445,
           -32'sd176461218},
         '{32'sd340391218, 32'sd340391218, 32'sd0, 32'sd392959389, 32'sd0} }
   };

   function automatic logic [SEC_W-1:0] section_count(input logic [BAND_W-1:0] band);
      logic [SEC_W-1:0] n;
      unique case (band)
         BAND_100HZ: n = 3'd1;
         BAND_200HZ: n = 3'd2;
         BAND_300HZ: n = 3'd2;
         BAND_500HZ: n = 3'd5;
         default:    n = 3'd1;
      endcase
      return n;
   endfunction

   function automatic uword_type mac_word(input src_sel_type src, input logic half_hi,
                                          input logic acc_en);
      uword_type w;
      w = '{src: src, half_hi: half_hi, acc_en: acc_en, sec_end: 1'b0, finish: 1'b0,
            load: 1'b0, jump: JMP_NEXT, target: UPC_IDLE};
      return w;
   endfunction

   // The microprogram: one load step, ten multiply steps (low and high half of
   // each of the five operands), a drain step, a section end that loops while
   // sections remain, and a finish step that waits for the output register.
   function automatic uword_type ucode_rom(input logic [UPC_W-1:0] upc);
      uword_type w;
      w = '{src: SRC_TAP0, half_hi: 1'b0, acc_en: 1'b0, sec_end: 1'b0, finish: 1'b0,
            load: 1'b0, jump: JMP_NEXT, target: UPC_IDLE};
      unique case (upc)
         UPC_IDLE: begin
            w.load   = 1'b1;
            w.jump   = JMP_WAIT_REQ;
            w.target = UPC_MAC_FIRST;
         end
         4'd1:  w = mac_word(SRC_TAP0,  1'b0, 1'b0);
         4'd2:  w = mac_word(SRC_TAP0,  1'b1, 1'b1);
         4'd3:  w = mac_word(SRC_TAP1,  1'b0, 1'b1);
         4'd4:  w = mac_word(SRC_TAP1,  1'b1, 1'b1);
         4'd5:  w = mac_word(SRC_TAP2,  1'b0, 1'b1);
         4'd6:  w = mac_word(SRC_TAP2,  1'b1, 1'b1);
         4'd7:  w = mac_word(SRC_HIST0, 1'b0, 1'b1);
         4'd8:  w = mac_word(SRC_HIST0, 1'b1, 1'b1);
         4'd9:  w = mac_word(SRC_HIST1, 1'b0, 1'b1);
         4'd10: w = mac_word(SRC_HIST1, 1'b1, 1'b1);
         UPC_ACC_LAST: w.acc_en = 1'b1;
         UPC_SEC_END: begin
            w.sec_end = 1'b1;
            w.jump    = JMP_MORE_SEC;
            w.target  = UPC_MAC_FIRST;
         end
         UPC_FINISH: begin
            w.finish = 1'b1;
            w.jump   = JMP_WAIT_OUT;
            w.target = UPC_IDLE;
         end
         default: begin
            w.jump   = JMP_GOTO;
            w.target = UPC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== src/cbal_sequencer.sv =====
// Microcode sequencer: step counter, program ROM, section counter and the
// handshake control. Depends on cbal_pkg.
`default_nettype none

module cbal_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [cbal_pkg::BAND_W-1:0]    band_select,
   input  logic                           req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output cbal_pkg::dp_ctrl_type          ctrl
);
   import cbal_pkg::*;

   logic [UPC_W-1:0] upc_ff, upc_in;
   logic [SEC_W-1:0] sec_ff, sec_in;
   logic             rsp_valid_ff, rsp_valid_in;
   uword_type        uw;
   logic             req_fire;
   logic             out_free;
   logic             more_sec;

   assign uw        = ucode_rom(upc_ff);
   assign req_ready = (upc_ff == UPC_IDLE) && !reset;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign more_sec  = (sec_ff + SEC_W'(1)) < section_count(band_select);
   assign rsp_valid = rsp_valid_ff;

   // Next step address.
   always_comb begin
      unique case (uw.jump)
         JMP_NEXT:     upc_in = upc_ff + UPC_W'(1);
         JMP_GOTO:     upc_in = uw.target;
         JMP_WAIT_REQ: upc_in = req_fire ? uw.target : upc_ff;
         JMP_MORE_SEC: upc_in = more_sec ? uw.target : upc_ff + UPC_W'(1);
         JMP_WAIT_OUT: upc_in = out_free ? uw.target : upc_ff;
         default:      upc_in = UPC_IDLE;
      endcase
   end

   always_comb begin
      priority if (uw.load) begin
         sec_in = '0;
      end else if (uw.sec_end && more_sec) begin
         sec_in = sec_ff + SEC_W'(1);
      end else begin
         sec_in = sec_ff;
      end
   end

   // Control word for the datapath.
   always_comb begin
      ctrl.src         = uw.src;
      ctrl.half_hi     = uw.half_hi;
      ctrl.acc_en      = uw.acc_en;
      ctrl.sec_end     = uw.sec_end;
      ctrl.load_fire   = uw.load && req_fire;
      ctrl.finish_fire = uw.finish && out_free;
      ctrl.sec         = sec_ff;
   end

   always_comb begin
      priority if (uw.finish && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UPC_IDLE;
         sec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         sec_ff       <= sec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/cbal_datapath.sv =====
// Datapath: tap and history registers, the shared split multiplier, the
// accumulator with scaling and saturation, and the output register.
// Depends on cbal_pkg.
`default_nettype none

module cbal_datapath #(
   parameter int FRAC_BITS = cbal_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cbal_pkg::dp_ctrl_type           ctrl,
   input  logic [cbal_pkg::BAND_W-1:0]     band_select,
   input  logic                            bypass,
   input  logic [cbal_pkg::SAMPLE_W-1:0]   req_angle_sample,
   output logic [cbal_pkg::SAMPLE_W-1:0]   rsp_filtered_angle,
   output logic                            rsp_clipped
);
   import cbal_pkg::*;

   // Operand width covers both the scaled input code and a section output.
   localparam int OPW     = (STATE_W > SAMPLE_W + 1 + FRAC_BITS) ? STATE_W
                                                                 : SAMPLE_W + 1 + FRAC_BITS;
   localparam int LO_W    = OPW / 2;
   localparam int HI_W    = OPW - LO_W;
   localparam int MUL_B_W = HI_W + 1;
   localparam int PROD_W  = COEF_W + MUL_B_W;
   localparam int ACC_W   = COEF_W + OPW + 3;
   localparam int IP_W    = STATE_W - 1 - FRAC_BITS;

   logic signed [OPW-1:0]     tap_ff [HISTORY_LEN];
   logic signed [OPW-1:0]     tap_in [HISTORY_LEN];
   logic signed [STATE_W-1:0] hist0_ff [MAX_SECTIONS];
   logic signed [STATE_W-1:0] hist1_ff [MAX_SECTIONS];
   logic [SAMPLE_W-1:0]       ih_ff [PAST];
   logic [SAMPLE_W-1:0]       code_ff;
   logic signed [ACC_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [SAMPLE_W-1:0]       out_ff, out_in;
   logic                      clip_ff, clip_in;

   logic signed [STATE_W-1:0] h0, h1;
   logic signed [OPW-1:0]     opnd;
   logic [2:0]                coef_idx;
   logic signed [COEF_W-1:0]  coef;
   logic [LO_W-1:0]           opnd_lo;
   logic signed [HI_W-1:0]    opnd_hi;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [ACC_W-1:0]   acc_sh;
   logic                      fits;
   logic signed [STATE_W-1:0] y;
   logic signed [STATE_W-1:0] yl;
   logic [STATE_W:0]          mag;
   logic [IP_W-1:0]           ip_u;
   logic [63:0]               ip_wide;

   assign h0       = hist0_ff[ctrl.sec];
   assign h1       = hist1_ff[ctrl.sec];
   assign coef_idx = ctrl.src;
   assign coef     = COEF_ROM[band_select][ctrl.sec][coef_idx];

   always_comb begin
      unique case (ctrl.src)
         SRC_TAP0:  opnd = tap_ff[0];
         SRC_TAP1:  opnd = tap_ff[1];
         SRC_TAP2:  opnd = tap_ff[2];
         SRC_HIST0: opnd = OPW'(h0);
         SRC_HIST1: opnd = OPW'(h1);
         default:   opnd = '0;
      endcase
   end

   // The operand is taken in two halves: unsigned low half, signed high half.
   always_comb begin
      opnd_lo  = opnd[LO_W-1:0];
      opnd_hi  = opnd[OPW-1:LO_W];
      mul_b    = ctrl.half_hi ? MUL_B_W'(opnd_hi) : $signed(MUL_B_W'({1'b0, opnd_lo}));
      prod     = coef * mul_b;
      prod_ext = ACC_W'(prod);
      prod_in  = ctrl.half_hi ? (prod_ext <<< LO_W) : prod_ext;
   end

   always_comb begin
      priority if (ctrl.load_fire || ctrl.sec_end) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + prod_ff;
      end else begin
         acc_in = acc_ff;
      end
   end

   // Floor shift by the coefficient scale, then saturate to the state width.
   always_comb begin
      acc_sh = acc_ff >>> COEF_SHIFT;
      fits   = (&acc_sh[ACC_W-1:STATE_W-1]) || !(|acc_sh[ACC_W-1:STATE_W-1]);
      if (fits) begin
         y = acc_sh[STATE_W-1:0];
      end else if (acc_sh[ACC_W-1]) begin
         y = {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         y = {1'b0, {(STATE_W-1){1'b1}}};
      end
   end

   always_comb begin
      priority if (ctrl.load_fire) begin
         tap_in[0] = OPW'({req_angle_sample, {FRAC_BITS{1'b0}}});
         tap_in[1] = OPW'({ih_ff[0], {FRAC_BITS{1'b0}}});
         tap_in[2] = OPW'({ih_ff[1], {FRAC_BITS{1'b0}}});
      end else if (ctrl.sec_end) begin
         tap_in[0] = OPW'(y);
         tap_in[1] = OPW'(h0);
         tap_in[2] = OPW'(h1);
      end else begin
         tap_in[0] = tap_ff[0];
         tap_in[1] = tap_ff[1];
         tap_in[2] = tap_ff[2];
      end
   end

   // Result: the last section output sits in the first tap.
   always_comb begin
      yl      = tap_ff[0][STATE_W-1:0];
      mag     = -{yl[STATE_W-1], yl};
      ip_u    = yl[STATE_W-2:FRAC_BITS];
      ip_wide = 64'(ip_u);
      if (bypass) begin
         out_in  = code_ff;
         clip_in = 1'b0;
      end else if (yl[STATE_W-1]) begin
         out_in  = '0;
         clip_in = |mag[STATE_W:FRAC_BITS];
      end else if (ip_wide > {32'd0, {SAMPLE_W{1'b1}}}) begin
         out_in  = {SAMPLE_W{1'b1}};
         clip_in = 1'b1;
      end else begin
         out_in  = ip_wide[SAMPLE_W-1:0];
         clip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      for (int i = 0; i < HISTORY_LEN; i++) begin
         tap_ff[i] <= tap_in[i];
      end
      if (ctrl.load_fire) begin
         code_ff <= req_angle_sample;
      end
      if (ctrl.finish_fire) begin
         out_ff  <= out_in;
         clip_ff <= clip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SECTIONS; i++) begin
            hist0_ff[i] <= '0;
            hist1_ff[i] <= '0;
         end
         for (int i = 0; i < PAST; i++) begin
            ih_ff[i] <= '0;
         end
      end else begin
         if (ctrl.sec_end) begin
            hist0_ff[ctrl.sec] <= y;
            hist1_ff[ctrl.sec] <= h0;
         end
         if (ctrl.finish_fire) begin
            ih_ff[1] <= ih_ff[0];
            ih_ff[0] <= code_ff;
         end
      end
   end

   assign rsp_filtered_angle = out_ff;
   assign rsp_clipped        = clip_ff;

endmodule

`default_nettype wire

// ===== src/cascaded_biquad_angle_lowpass.sv =====
// Top level of the cascaded biquad angle low-pass filter: configuration
// registers and the sequencer and datapath. Depends on cbal_pkg,
// cbal_sequencer and cbal_datapath.
//
// Usage: an angle code enters on the req_ channel (valid/ready); one result
// item leaves on the rsp_ channel with the filtered code and a clip flag.
// Registers are written on the csr_ channel, which is ready whenever reset is
// low: index 0 selects the band, index 1 the bypass; other indexes are
// ignored. Write them only while no item is in flight.
// One item is worked at a time. A shared 32-bit-coefficient multiplier takes
// each of the five products of a section in two halves; the bands use
// 1, 2, 2 or 5 sections. The next item is accepted only once the result
// has gone to the output register and the block is back in its idle step.
// The output register holds the result while the receiver stalls; the block
// still accepts the next item and computes it, then waits in its last step
// until the held result is taken.
// Synchronous reset clears all filter history, empties the output register,
// holds both ready outputs low and sets band_select to 1 and bypass to 1.
`default_nettype none

module cascaded_biquad_angle_lowpass #(
   parameter int FRAC_BITS = cbal_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cbal_pkg::SAMPLE_W-1:0]     req_angle_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cbal_pkg::SAMPLE_W-1:0]     rsp_filtered_angle,
   output logic                              rsp_clipped,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cbal_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cbal_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cbal_pkg::*;

   logic [BAND_W-1:0] band_ff, band_in;
   logic              bypass_ff, bypass_in;
   dp_ctrl_type       ctrl;

   // The register file takes a write in every cycle outside reset.
   assign csr_ready = !reset;

   // Only the register's own width is kept from the write data.
   always_comb begin
      band_in   = band_ff;
      bypass_in = bypass_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BAND_SELECT: band_in   = csr_wdata[BAND_W-1:0];
            CSR_BYPASS:      bypass_in = csr_wdata[0];
            default: begin
               band_in   = band_ff;
               bypass_in = bypass_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff   <= BAND_200HZ;
         bypass_ff <= 1'b1;
      end else begin
         band_ff   <= band_in;
         bypass_ff <= bypass_in;
      end
   end

   cbal_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .band_select (band_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .ctrl        (ctrl)
   );

   cbal_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .band_select        (band_ff),
      .bypass             (bypass_ff),
      .req_angle_sample   (req_angle_sample),
      .rsp_filtered_angle (rsp_filtered_angle),
      .rsp_clipped        (rsp_clipped)
   );

endmodule

`default_nettype wire

// ===== src/cbal_checker.sv =====
// Port-level checks for the cascaded biquad angle low-pass filter, bound to
// the top level. Depends only on the top level's ports.
`default_nettype none

module cbal_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_filtered_angle,
   input logic        rsp_clipped
);

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Only one item is in the filter at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken while one is in work");

   // A result never appears in the cycle right after an item is taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result too early");

   // A clamped result sits at one end of the unsigned range.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_filtered_angle == 32'd0 || rsp_filtered_angle == 32'hFFFF_FFFF))
      else $error("clip flag with an unclamped value");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_filtered_angle) && $stable(rsp_clipped)))
      else $error("stalled result changed");

endmodule

bind cascaded_biquad_angle_lowpass cbal_checker u_cbal_checker (.*);

`default_nettype wire
